// ===== rtl/cdw_pkg.sv =====
// ----------------------------------------------------------------------------
// cdw_pkg: shared types and constants of the endpoint walker
// Result record layout, status codes, descriptor constants and register map.
// ----------------------------------------------------------------------------
package cdw_pkg;

  // Walk status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_IO       = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  // Result kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Descriptor constants
  localparam logic [7:0] TYPE_ENDPOINT = 8'd5;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;
  localparam logic [7:0] DESC_MIN_LEN  = 8'd2;
  localparam logic [7:0] EP_LAST_OFF   = 8'd6;
  localparam logic [3:0] MIN_STREAM    = 4'd9;
  localparam logic [1:0] XFER_BULK     = 2'd2;
  localparam logic [1:0] XFER_INTR     = 2'd3;
  localparam int         EP_BYTES      = 5;

  // Register map (index taken from the word address)
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;
  localparam logic [9:0] LIMIT_RESET = 10'd64;

  // Result queue depth is 2**CDW_FIFO_AW, at least 4 entries
  localparam int CDW_FIFO_AW = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cdw_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  addr;
    logic [7:0]  attr;
    logic [10:0] size;
    logic [7:0]  intv;
    logic [1:0]  status;
    logic        fin;
  } cdw_result_t;

  // Up to two results per byte: a record first, then the final status
  typedef struct packed {
    logic        rec_valid;
    logic        stat_valid;
    cdw_result_t rec;
    cdw_result_t stat;
  } cdw_push_t;

endpackage

// ===== rtl/cdw_walk.sv =====
// ----------------------------------------------------------------------------
// cdw_walk: descriptor walk state and per-byte checks
// Consumes the registered byte, updates the walk state and presents up to
// two results (endpoint record, final status) for the result queue.
// ----------------------------------------------------------------------------
module cdw_walk import cdw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  cdw_item_t  item,
  input  logic       walk_mode,
  input  logic [9:0] max_packet_limit,
  output cdw_push_t  push
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  ep_r [EP_BYTES];
  logic [7:0]  ep_nxt [EP_BYTES];
  logic [1:0]  err_r, err_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  cdw_result_t pend_r, pend_nxt;

  logic [7:0]  b;
  logic [10:0] size;
  logic [10:0] limit_ext;
  logic [1:0]  xfer;
  cdw_result_t new_rec;

  assign b         = item.data;
  assign limit_ext = {1'b0, max_packet_limit};

  // Endpoint fields as they stand after this byte
  assign size = {ep_nxt[3][2:0], ep_nxt[2]};
  assign xfer = ep_nxt[1][1:0];

  always_comb begin
    new_rec        = '0;
    new_rec.kind   = KIND_RECORD;
    new_rec.addr   = ep_nxt[0];
    new_rec.attr   = ep_nxt[1];
    new_rec.size   = (size > limit_ext) ? limit_ext : size;
    new_rec.intv   = ep_nxt[4];
    new_rec.status = ST_OK;
    new_rec.fin    = 1'b0;
  end

  // Next walk state and results for one byte
  always_comb begin
    cnt_nxt        = cnt_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    ep_nxt         = ep_r;
    err_nxt        = err_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    push           = '0;
    if (item_valid) begin
      if (cnt_r < MIN_STREAM) begin
        cnt_nxt = cnt_r + 4'd1;
      end
      if (err_r == ST_OK) begin
        // Capture the byte by its place in the descriptor
        if (off_r == 8'd0) begin
          len_nxt = b;
          if (b < DESC_MIN_LEN) begin
            err_nxt = ST_IO;
          end
        end else if (off_r == 8'd1) begin
          type_nxt = b;
        end else if (off_r <= EP_LAST_OFF) begin
          ep_nxt[off_r[2:0] - 3'd2] = b;
        end
        // Check descriptor length and finish a descriptor
        if (err_nxt == ST_OK) begin
          if (off_r == 8'd1 && b == TYPE_ENDPOINT && len_r < EP_MIN_LEN) begin
            err_nxt = ST_IO;
          end else if (off_r != 8'd0 && ({1'b0, off_r} + 9'd1) == {1'b0, len_r}) begin
            off_nxt = 8'd0;
            if (type_nxt == TYPE_ENDPOINT && (xfer == XFER_BULK || xfer == XFER_INTR)) begin
              if (size == 11'd0) begin
                err_nxt = ST_IO;
              end else if (size > limit_ext && !walk_mode) begin
                err_nxt = ST_OVERFLOW;
              end else if (walk_mode) begin
                if (cnt_nxt == MIN_STREAM) begin
                  push.rec_valid = 1'b1;
                  push.rec       = new_rec;
                end else begin
                  pend_valid_nxt = 1'b1;
                  pend_nxt       = new_rec;
                end
              end
            end
          end else begin
            off_nxt = off_r + 8'd1;
          end
        end
      end
      // Flush a record held back until the stream is long enough
      if (pend_valid_r && cnt_nxt == MIN_STREAM) begin
        push.rec_valid = 1'b1;
        push.rec       = pend_r;
        pend_valid_nxt = 1'b0;
      end
      // Final status, then return the walk to its reset state
      if (item.last) begin
        if (err_nxt == ST_OK && off_nxt != 8'd0) begin
          err_nxt = ST_IO;
        end
        push.stat_valid  = 1'b1;
        push.stat.kind   = KIND_STATUS;
        push.stat.status = (walk_mode && cnt_nxt < MIN_STREAM) ? ST_INVALID : err_nxt;
        push.stat.fin    = 1'b1;
        cnt_nxt        = '0;
        off_nxt        = '0;
        len_nxt        = '0;
        type_nxt       = '0;
        err_nxt        = ST_OK;
        pend_valid_nxt = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      off_r        <= '0;
      len_r        <= '0;
      type_r       <= '0;
      err_r        <= ST_OK;
      pend_valid_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      off_r        <= off_nxt;
      len_r        <= len_nxt;
      type_r       <= type_nxt;
      err_r        <= err_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Endpoint fields and held record
  always_ff @(posedge clk) begin
    ep_r   <= ep_nxt;
    pend_r <= pend_nxt;
  end

endmodule

// ===== rtl/cdw_rfifo.sv =====
// ----------------------------------------------------------------------------
// cdw_rfifo: result queue
// Takes up to two results per cycle and hands one result per transaction
// to the output channel.
// ----------------------------------------------------------------------------
module cdw_rfifo import cdw_pkg::*; #(
  parameter int FifoAw = CDW_FIFO_AW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdw_push_t         push,
  input  logic              pop_ready,
  output logic              pop_valid,
  output cdw_result_t       pop_data,
  output logic [FifoAw:0]   count
);

  localparam int Depth = 1 << FifoAw;

  cdw_result_t       mem [Depth];
  logic [FifoAw-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FifoAw-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FifoAw:0]   count_r, count_nxt;
  logic [FifoAw-1:0] stat_ptr;
  logic [1:0]        push_n;
  logic              pop;

  assign push_n    = {1'b0, push.rec_valid} + {1'b0, push.stat_valid};
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr_r];
  assign count     = count_r;
  assign stat_ptr  = push.rec_valid ? wr_ptr_r + 1'b1 : wr_ptr_r;

  assign wr_ptr_nxt = wr_ptr_r + FifoAw'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + FifoAw'(pop);
  assign count_nxt  = count_r + (FifoAw+1)'(push_n) - (FifoAw+1)'(pop);

  // Store the record first, the status behind it
  always_ff @(posedge clk) begin
    if (push.rec_valid) begin
      mem[wr_ptr_r] <= push.rec;
    end
    if (push.stat_valid) begin
      mem[stat_ptr] <= push.stat;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FifoAw+1)'(Depth))
    else $error("result queue count above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} + (FifoAw+2)'(push_n)) <= ((FifoAw+2)'(Depth) + (FifoAw+2)'(pop)))
    else $error("result queue overrun");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == 2'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("result queue count did not drop on a lone transaction");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[FifoAw-1:0])
    else $error("result queue pointers disagree with count");

endmodule

// ===== rtl/usb_config_descriptor_endpoint_walker.sv =====
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_walker: configuration descriptor walker
// Walks a configuration descriptor byte stream, checks bulk and interrupt
// endpoints against the packet size limit and reports records and status.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one descriptor byte per transaction, in_tlast on the final byte.
//   out_* : endpoint records (out_tuser 0) and one final status per stream
//           (out_tuser 1, out_tlast 1). A byte yields zero, one or two results.
//   cfg_* : APB-style registers, walk_mode at 0x0, max_packet_limit at 0x4;
//           write them only while no stream is in flight.
// Order: a taken byte first enters the input register; its results are then
//   written into the result queue and shown on out_tvalid from there on.
// Throughput: one byte per cycle while in_tready is high; the input register
//   and the result queue of 2**FifoAw entries set that figure, and one
//   result leaves per cycle while out_tready is high.
// Reset: walk state cleared, walk_mode 0, max_packet_limit 64, queue empty.
// Stall: while out_tready is low results collect in the queue; in_tready
//   drops once the queue cannot take two more results per byte in flight.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_walker import cdw_pkg::*; #(
  parameter int FifoAw = CDW_FIFO_AW
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] endpoint_address, [15:8] endpoint_attributes,
                                  // [26:16] max_pkt_size, [34:27] poll_interval,
                                  // [36:35] walk_status, [39:37] zero
  output logic        out_tuser,  // result_kind
  output logic        out_tlast,  // final_flag
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int Depth = 1 << FifoAw;

  logic              mode_r;
  logic [9:0]        limit_r;
  logic              cfg_wr;
  logic              stage_valid_r;
  cdw_item_t         stage_r;
  logic              in_acc;
  logic [FifoAw:0]   q_count;
  logic [FifoAw+2:0] q_need;
  cdw_push_t         push;
  cdw_result_t       res;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODE) ? {31'd0, mode_r} : {22'd0, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MODE) begin
        mode_r <= cfg_pwdata[0];
      end else begin
        limit_r <= cfg_pwdata[9:0];
      end
    end
  end

  // Accept a byte when the queue has room for this one and the one in flight
  assign q_need    = (FifoAw+3)'(q_count) + (stage_valid_r ? (FifoAw+3)'(4) : (FifoAw+3)'(2));
  assign in_tready = (q_need <= (FifoAw+3)'(Depth));
  assign in_acc    = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r.data <= in_tdata;
      stage_r.last <= in_tlast;
    end
  end

  cdw_walk u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (stage_valid_r),
    .item             (stage_r),
    .walk_mode        (mode_r),
    .max_packet_limit (limit_r),
    .push             (push)
  );

  cdw_rfifo #(
    .FifoAw (FifoAw)
  ) u_rfifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (res),
    .count     (q_count)
  );

  // Pack the result onto the output channel
  assign out_tdata = {3'd0, res.status, res.intv, res.size, res.attr, res.addr};
  assign out_tuser = res.kind;
  assign out_tlast = res.fin;

endmodule

// ===== tb/usb_config_descriptor_endpoint_walker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// usb_config_descriptor_endpoint_walker_test: self-checking walker testbench
// Feeds configuration descriptor byte streams through the input channel,
// predicts endpoint records and final status per byte, and checks every
// result transaction in order. A short directed table comes first, then
// random well-formed, short, broken and noise streams over several register
// settings, with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module usb_config_descriptor_endpoint_walker_test;
  import cdw_pkg::*;

  localparam int         UNTYPED        = -1;
  localparam logic [7:0] TYPE_CONFIG    = 8'd2;
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] CONFIG_LEN     = 8'd9;
  localparam logic [7:0] IFACE_LEN      = 8'd9;
  localparam int         PHASE_BYTES    = 102;
  localparam int         HOLD_CYCLES    = 1500;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  usb_config_descriptor_endpoint_walker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Register copies
  logic       mode_q  = 1'b0;
  logic [9:0] limit_q = LIMIT_RESET;

  // Walk state of the predictor
  logic [3:0]  seen_cnt  = '0;
  logic [7:0]  desc_off  = '0;
  logic [7:0]  desc_len  = '0;
  logic [7:0]  desc_code = '0;
  logic [39:0] ep_bytes  = '0;
  logic [1:0]  walk_err  = ST_OK;
  logic        held_ok   = 1'b0;
  cdw_result_t held_rec  = '0;

  cdw_result_t due_results [$];
  logic [7:0]  stream_q [$];
  int          row_status = UNTYPED;
  int          n_fail     = 0;
  bit          in_burst   = 1'b0;
  bit          out_burst  = 1'b0;
  bit          hold_req   = 1'b0;

  // Directed streams: final status typed where it is plain
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       mode;
    int         status;
  } dir_row_t;

  dir_row_t dir_tab [0:22] = '{
    // length under two
    '{8'h01, 1'b1, 1'b0, ST_IO},
    // stream ends inside a descriptor
    '{8'h03, 1'b0, 1'b0, UNTYPED},
    '{8'h04, 1'b1, 1'b0, ST_IO},
    // endpoint shorter than seven
    '{8'h06, 1'b0, 1'b0, UNTYPED},
    '{8'h05, 1'b1, 1'b0, ST_IO},
    // bulk endpoint, size 2047 above the limit
    '{8'h07, 1'b0, 1'b0, UNTYPED},
    '{8'h05, 1'b0, 1'b0, UNTYPED},
    '{8'h81, 1'b0, 1'b0, UNTYPED},
    '{8'h02, 1'b0, 1'b0, UNTYPED},
    '{8'hff, 1'b0, 1'b0, UNTYPED},
    '{8'hff, 1'b0, 1'b0, UNTYPED},
    '{8'hff, 1'b1, 1'b0, ST_OVERFLOW},
    // open mode, short stream
    '{8'h02, 1'b0, 1'b1, UNTYPED},
    '{8'hff, 1'b1, 1'b1, ST_INVALID},
    // open mode, clamped interrupt endpoint held until byte nine
    '{8'h07, 1'b0, 1'b1, UNTYPED},
    '{8'h05, 1'b0, 1'b1, UNTYPED},
    '{8'h82, 1'b0, 1'b1, UNTYPED},
    '{8'h03, 1'b0, 1'b1, UNTYPED},
    '{8'hff, 1'b0, 1'b1, UNTYPED},
    '{8'hff, 1'b0, 1'b1, UNTYPED},
    '{8'h00, 1'b0, 1'b1, UNTYPED},
    '{8'h02, 1'b0, 1'b1, UNTYPED},
    '{8'h00, 1'b1, 1'b1, ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Advance the walk by one byte and queue the results it causes
  function automatic void walk_byte(input logic [7:0] d, input logic l, input int typed);
    logic [7:0]  off;
    logic [10:0] sz;
    cdw_result_t rec;
    off = desc_off;
    if (seen_cnt < MIN_STREAM) seen_cnt++;
    if (walk_err == ST_OK) begin
      if (off == 0) begin
        desc_len = d;
        ep_bytes = '0;
        if (d < DESC_MIN_LEN) walk_err = ST_IO;
      end else if (off == 1) begin
        desc_code = d;
      end else if (off <= EP_LAST_OFF) begin
        ep_bytes[8*(off-2) +: 8] = d;
      end
      if (walk_err == ST_OK) begin
        if (off == 1 && d == TYPE_ENDPOINT && desc_len < EP_MIN_LEN) begin
          walk_err = ST_IO;
        end else if (off >= 1 && off + 1 == desc_len) begin
          desc_off = '0;
          sz = ep_bytes[26:16];
          if (desc_code == TYPE_ENDPOINT &&
              (ep_bytes[9:8] == XFER_BULK || ep_bytes[9:8] == XFER_INTR)) begin
            if (sz == 0) begin
              walk_err = ST_IO;
            end else if (sz > limit_q && !mode_q) begin
              walk_err = ST_OVERFLOW;
            end else if (mode_q) begin
              if (sz > limit_q) sz = {1'b0, limit_q};
              rec = '{kind: KIND_RECORD, addr: ep_bytes[7:0], attr: ep_bytes[15:8],
                      size: sz, intv: ep_bytes[39:32], status: ST_OK, fin: 1'b0};
              if (seen_cnt >= MIN_STREAM) begin
                due_results.push_back(rec);
              end else begin
                held_rec = rec;
                held_ok  = 1'b1;
              end
            end
          end
        end else begin
          desc_off = off + 8'd1;
        end
      end
    end
    // Release a record held back before byte nine
    if (held_ok && seen_cnt >= MIN_STREAM) begin
      due_results.push_back(held_rec);
      held_ok = 1'b0;
    end
    if (l) begin
      if (walk_err == ST_OK && desc_off != 0) walk_err = ST_IO;
      rec        = '0;
      rec.kind   = KIND_STATUS;
      rec.fin    = 1'b1;
      rec.status = (mode_q && seen_cnt < MIN_STREAM) ? ST_INVALID : walk_err;
      if (typed != UNTYPED) rec.status = typed[1:0];
      due_results.push_back(rec);
      seen_cnt  = '0;
      desc_off  = '0;
      desc_len  = '0;
      desc_code = '0;
      ep_bytes  = '0;
      walk_err  = ST_OK;
      held_ok   = 1'b0;
      held_rec  = '0;
    end
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      n_fail++;
    end
  endfunction

  // Predict on each input transaction, check each result transaction
  always @(posedge clk) begin : watch
    cdw_result_t got;
    cdw_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) walk_byte(in_tdata, in_tlast, row_status);
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.addr   = out_tdata[7:0];
        got.attr   = out_tdata[15:8];
        got.size   = out_tdata[26:16];
        got.intv   = out_tdata[34:27];
        got.status = out_tdata[36:35];
        got.fin    = out_tlast;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, got);
          n_fail++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.kind, got.kind);
          check_field("endpoint_address", want.addr, got.addr);
          check_field("endpoint_attributes", want.attr, got.attr);
          check_field("max_pkt_size", want.size, got.size);
          check_field("poll_interval", want.intv, got.intv);
          check_field("walk_status", want.status, got.status);
          check_field("final_flag", want.fin, got.fin);
        end
      end
    end
  end

  // Result side: random stalls per transaction, one long hold-off on request
  initial begin : sink
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        stall = out_burst ? 0 : $urandom_range(0, 13);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] d, input logic l, input int st);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= d;
    in_tlast   <= l;
    row_status <= st;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every due result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // Write a register, then read it back
  task automatic cfg_write(input logic idx, input logic [31:0] val);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_MODE) mode_q = val[0];
    else limit_q = val[9:0];
    want = (idx == REG_MODE) ? {31'b0, mode_q} : {22'b0, limit_q};
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d read mismatch: expected %0h, got %0h",
               $time, idx, want, cfg_prdata);
      n_fail++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Build one random stream: mostly well-formed, some short, broken or noise
  task automatic make_stream();
    int          pick;
    int          n_sub;
    int          len;
    int          sub_pick;
    logic [15:0] sz;
    logic [7:0]  attr;
    stream_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      len = $urandom_range(1, 20);
      repeat (len) stream_q.push_back(8'($urandom));
    end else begin
      // configuration header, left out for short streams
      if (pick >= 18) begin
        stream_q.push_back(CONFIG_LEN);
        stream_q.push_back(TYPE_CONFIG);
        repeat (CONFIG_LEN - 2) stream_q.push_back(8'($urandom));
      end
      n_sub = (pick >= 18) ? $urandom_range(0, 4) : $urandom_range(1, 2);
      repeat (n_sub) begin
        sub_pick = $urandom_range(0, 9);
        if (sub_pick < 6) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 10) : EP_MIN_LEN;
          case ($urandom_range(0, 11))
            0:       sz = '0;
            1:       sz = 16'd1;
            2:       sz = {6'b0, limit_q};
            3:       sz = {6'b0, limit_q} + 16'd1;
            4:       sz = 16'h07ff;
            5:       sz = 16'($urandom_range(0, 2047));
            6:       sz = 16'($urandom);
            default: sz = 16'($urandom_range(1, limit_q));
          endcase
          attr = 8'($urandom);
          if ($urandom_range(0, 3) != 0) attr[1] = 1'b1;
          stream_q.push_back(8'(len));
          stream_q.push_back(TYPE_ENDPOINT);
          stream_q.push_back(8'($urandom));
          stream_q.push_back(attr);
          stream_q.push_back(sz[7:0]);
          stream_q.push_back(sz[15:8]);
          stream_q.push_back(8'($urandom));
          repeat (len - EP_MIN_LEN) stream_q.push_back(8'($urandom));
        end else if (sub_pick < 8) begin
          stream_q.push_back(IFACE_LEN);
          stream_q.push_back(TYPE_INTERFACE);
          repeat (IFACE_LEN - 2) stream_q.push_back(8'($urandom));
        end else begin
          len = $urandom_range(2, 12);
          stream_q.push_back(8'(len));
          stream_q.push_back(($urandom_range(0, 7) == 0) ? TYPE_ENDPOINT : 8'($urandom));
          repeat (len - 2) stream_q.push_back(8'($urandom));
        end
      end
      if (stream_q.size() == 0) stream_q.push_back(8'($urandom));
      // break a few: cut short or corrupt one byte
      if (pick >= 92) begin
        if ($urandom_range(0, 1) == 1 && stream_q.size() > 1) begin
          len = $urandom_range(1, stream_q.size() - 1);
          while (stream_q.size() > len) void'(stream_q.pop_back());
        end else begin
          stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom);
        end
      end
    end
  endtask

  initial begin : stim
    logic        ph_mode  [0:7];
    logic [9:0]  ph_limit [0:7];
    int          sent;
    ph_mode  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    ph_limit = '{10'd1023, 10'd1, 10'd0, 10'd0, 10'd1023, 10'd1,
                 10'($urandom_range(1, 1022)), 10'($urandom_range(1, 1022))};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, switching mode between its streams
    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != mode_q) begin
        drain();
        cfg_write(REG_MODE, {31'b0, dir_tab[i].mode});
      end
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].status);
    end

    // Random streams over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      cfg_write(REG_MODE, {31'b0, ph_mode[ph]});
      cfg_write(REG_LIMIT, {22'b0, ph_limit[ph]});
      // fill the block against a long output hold-off
      if (ph == 4) begin
        hold_req = 1'b1;
        in_burst = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        make_stream();
        foreach (stream_q[i])
          send_byte(stream_q[i], i == stream_q.size() - 1, UNTYPED);
        sent += stream_q.size();
      end
    end

    drain();
    if (n_fail == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
